// ===== rtl/bdr_pkg.sv =====
`timescale 1ns / 1ps

package bdr_pkg;

  typedef logic [6:0] duty_t;

  typedef enum logic [2:0] {
    REG_SCREEN_MIN,
    REG_SCREEN_MAX,
    REG_TRACKER_MAX,
    REG_TRACKER_STEP,
    REG_CHANGE_BAND,
    REG_TRACKER_HOLD,
    REG_LIMIT_HOLD,
    REG_SLEW_DIVIDER
  } reg_idx_t;

  localparam int CFG_DATA_W = 10;

  typedef struct packed {
    duty_t       screen_min;
    duty_t       screen_max;
    duty_t       tracker_max;
    logic [3:0]  tracker_step;
    logic [3:0]  change_band;
    logic [9:0]  tracker_hold;
    logic [7:0]  limit_hold;
    logic [3:0]  slew_divider;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    screen_min:   7'd1,
    screen_max:   7'd80,
    tracker_max:  7'd80,
    tracker_step: 4'd2,
    change_band:  4'd2,
    tracker_hold: 10'd500,
    limit_hold:   8'd200,
    slew_divider: 4'd3
  };

  localparam duty_t BRIGHT_FULL  = 7'd80;
  localparam duty_t LIMIT_RESET  = 7'd80;
  localparam duty_t TARGET_RESET = 7'd50;

  function automatic logic out_of_band(duty_t value, duty_t center, logic [3:0] band);
    logic [7:0] v;
    logic [7:0] c;
    logic [7:0] b;
    v = {1'b0, value};
    c = {1'b0, center};
    b = {4'b0, band};
    return ((v + b) < c) || (v > (c + b));
  endfunction

endpackage

// ===== rtl/bdr_poll_if.sv =====
`timescale 1ns / 1ps

interface bdr_poll_if;
  logic valid;
  logic ready;
  logic pwm_in_level;
  logic comparator_high;
  logic tick_10us;
  logic tick_10ms;

  modport source (output valid, pwm_in_level, comparator_high, tick_10us, tick_10ms,
                  input ready);
  modport sink   (input valid, pwm_in_level, comparator_high, tick_10us, tick_10ms,
                  output ready);
endinterface

// ===== rtl/bdr_duty_if.sv =====
`timescale 1ns / 1ps

interface bdr_duty_if;
  logic                valid;
  logic                ready;
  bdr_pkg::duty_t      screen_duty;
  bdr_pkg::duty_t      tracker_duty;
  bdr_pkg::duty_t      brightness_target;
  bdr_pkg::duty_t      duty_limit;

  modport source (output valid, screen_duty, tracker_duty, brightness_target, duty_limit,
                  input ready);
  modport sink   (input valid, screen_duty, tracker_duty, brightness_target, duty_limit,
                  output ready);
endinterface

// ===== rtl/bdr_cfg_if.sv =====
`timescale 1ns / 1ps

interface bdr_cfg_if;
  logic                              valid;
  logic                              ready;
  bdr_pkg::reg_idx_t                 index;
  logic [bdr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bdr_tracker.sv =====
`timescale 1ns / 1ps

module bdr_tracker #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            comparator_high,
  input  bdr_pkg::cfg_t   cfg,
  output bdr_pkg::duty_t  tracker_next,
  output bdr_pkg::duty_t  target_next
);
  import bdr_pkg::*;

  localparam int SLOT_W      = $clog2(WINDOW_DEPTH);
  localparam int SUM_W       = 7 + $clog2(WINDOW_DEPTH);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  duty_t               tracker_value;
  logic [SLOT_W-1:0]   window_slot;
  logic [SUM_W-1:0]    window_sum;
  duty_t               window_average;
  duty_t               accepted_average;
  logic [9:0]          tracker_persist;
  duty_t               target_value;

  duty_t                     tracker_new;
  logic [7:0]                rise;
  logic [SUM_W-1:0]          block_sum;
  logic [SUM_W+RECIP_W-1:0]  product;
  duty_t                     average_new;
  logic                      block_end;
  logic [9:0]                persist_inc;
  logic [9:0]                persist_new;
  duty_t                     accepted_new;
  duty_t                     target_new;

  always_comb begin
    rise = {1'b0, tracker_value} + {4'b0, cfg.tracker_step};
    if (comparator_high) begin
      if (tracker_value < cfg.tracker_max) begin
        tracker_new = (rise > {1'b0, cfg.tracker_max}) ? cfg.tracker_max : rise[6:0];
      end else begin
        tracker_new = tracker_value;
      end
    end else if (tracker_value > {3'b0, cfg.tracker_step}) begin
      tracker_new = tracker_value - {3'b0, cfg.tracker_step};
    end else begin
      tracker_new = '0;
    end

    block_end   = (window_slot == LAST_SLOT);
    block_sum   = window_sum + SUM_W'(tracker_new);
    product     = block_sum * RECIP;
    average_new = block_end ? product[RECIP_SHIFT +: 7] : window_average;

    persist_inc  = tracker_persist + 10'd1;
    persist_new  = '0;
    accepted_new = accepted_average;
    target_new   = target_value;
    if (out_of_band(average_new, accepted_average, cfg.change_band)) begin
      if (persist_inc >= cfg.tracker_hold) begin
        accepted_new = average_new;
        target_new   = (average_new < BRIGHT_FULL) ? BRIGHT_FULL - average_new : '0;
      end else begin
        persist_new = persist_inc;
      end
    end
  end

  assign tracker_next = step ? tracker_new : tracker_value;
  assign target_next  = step ? target_new : target_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracker_value    <= '0;
      window_slot      <= '0;
      window_sum       <= '0;
      window_average   <= '0;
      accepted_average <= '0;
      tracker_persist  <= '0;
      target_value     <= TARGET_RESET;
    end else if (step) begin
      tracker_value    <= tracker_new;
      window_slot      <= block_end ? '0 : window_slot + SLOT_W'(1);
      window_sum       <= block_end ? '0 : block_sum;
      window_average   <= average_new;
      accepted_average <= accepted_new;
      tracker_persist  <= persist_new;
      target_value     <= target_new;
    end
  end

endmodule

// ===== rtl/backlight_duty_regulator.sv =====
`timescale 1ns / 1ps

// Backlight duty regulator.
// poll: one beat per poll of the PWM input level, comparator output and the
//   10us / 10ms tick flags. cfg: register writes (index, data), always ready;
//   write only while no poll is in flight.
// result: one beat per poll with the screen duty, tracking duty, brightness
//   target and duty limit as they stand after that poll.
// A poll is taken into an input register and worked in one pass into the result
//   register, where it stays valid until the receiver takes it.
//   One poll per cycle is sustained while the receiver is ready; the limit,
//   tracker and slew updates all sit in the single stage between the input and
//   result registers.
// When the receiver stalls, the result register holds and the input register
//   still takes one more poll; ready then drops until the result is taken.
// Reset clears the pipeline, restores register defaults, sets the limit to
//   80, the brightness target to 50 and the screen duty to 0.
module backlight_duty_regulator #(
  parameter int PWM_PERIOD_TICKS = 100,
  parameter int WINDOW_DEPTH     = 4
) (
  input  logic         clk,
  input  logic         rst,
  bdr_poll_if.sink     poll,
  bdr_duty_if.source   result,
  bdr_cfg_if.sink      cfg
);
  import bdr_pkg::*;

  localparam logic [7:0] COUNT_CEIL = 8'(PWM_PERIOD_TICKS + 5);
  localparam duty_t      PERIOD_VAL = 7'(PWM_PERIOD_TICKS);

  cfg_t cfg_regs;

  logic  s1_valid;
  logic  s1_level;
  logic  s1_cmp;
  logic  s1_t10us;
  logic  s1_t10ms;
  logic  advance;

  logic  out_valid;
  duty_t out_screen;
  duty_t out_tracker;
  duty_t out_target;
  duty_t out_limit;

  duty_t       high_count;
  duty_t       measured_width;
  duty_t       accepted_width;
  logic [7:0]  limit_persist;
  duty_t       limit_value;
  logic [3:0]  slew_phase;
  duty_t       screen_value;

  duty_t       high_count_next;
  duty_t       measured_width_next;
  duty_t       accepted_width_next;
  logic [7:0]  limit_persist_next;
  duty_t       limit_value_next;
  logic [3:0]  slew_phase_next;
  duty_t       screen_value_next;
  logic [7:0]  count_inc;
  logic [7:0]  persist_inc;
  logic [3:0]  phase_inc;
  duty_t       goal;

  duty_t       tracker_next;
  duty_t       target_next;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign poll.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCREEN_MIN:   cfg_regs.screen_min   <= cfg.data[6:0];
        REG_SCREEN_MAX:   cfg_regs.screen_max   <= cfg.data[6:0];
        REG_TRACKER_MAX:  cfg_regs.tracker_max  <= cfg.data[6:0];
        REG_TRACKER_STEP: cfg_regs.tracker_step <= cfg.data[3:0];
        REG_CHANGE_BAND:  cfg_regs.change_band  <= cfg.data[3:0];
        REG_TRACKER_HOLD: cfg_regs.tracker_hold <= cfg.data[9:0];
        REG_LIMIT_HOLD:   cfg_regs.limit_hold   <= cfg.data[7:0];
        REG_SLEW_DIVIDER: cfg_regs.slew_divider <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.valid && poll.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_level <= poll.pwm_in_level;
      s1_cmp   <= poll.comparator_high;
      s1_t10us <= poll.tick_10us;
      s1_t10ms <= poll.tick_10ms;
    end
  end

  bdr_tracker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_tracker (
    .clk             (clk),
    .rst             (rst),
    .step            (advance && s1_t10ms),
    .comparator_high (s1_cmp),
    .cfg             (cfg_regs),
    .tracker_next    (tracker_next),
    .target_next     (target_next)
  );

  always_comb begin
    high_count_next     = high_count;
    measured_width_next = measured_width;
    count_inc           = {1'b0, high_count} + 8'd1;
    if (s1_level) begin
      if (s1_t10us) begin
        if (count_inc > COUNT_CEIL) begin
          measured_width_next = PERIOD_VAL;
          high_count_next     = PERIOD_VAL;
        end else begin
          high_count_next = count_inc[6:0];
        end
      end
    end else begin
      if (high_count != '0) begin
        measured_width_next = high_count;
      end
      high_count_next = '0;
    end

    accepted_width_next = accepted_width;
    limit_persist_next  = limit_persist;
    limit_value_next    = limit_value;
    slew_phase_next     = slew_phase;
    screen_value_next   = screen_value;
    persist_inc         = limit_persist + 8'd1;
    phase_inc           = slew_phase + 4'd1;
    goal                = '0;

    if (s1_t10ms) begin
      if (out_of_band(measured_width_next, accepted_width, cfg_regs.change_band)) begin
        if (persist_inc >= cfg_regs.limit_hold) begin
          limit_persist_next  = '0;
          limit_value_next    = measured_width_next;
          accepted_width_next = measured_width_next;
        end else begin
          limit_persist_next = persist_inc;
        end
      end else begin
        limit_persist_next = '0;
      end

      if (phase_inc < cfg_regs.slew_divider) begin
        slew_phase_next = phase_inc;
      end else begin
        slew_phase_next = '0;
        if ((target_next > limit_value_next) && (limit_value_next != '0)) begin
          goal = limit_value_next;
        end else begin
          goal = target_next;
        end
        if (goal > cfg_regs.screen_max) begin
          goal = cfg_regs.screen_max;
        end else if (goal < cfg_regs.screen_min) begin
          goal = cfg_regs.screen_min;
        end
        if (screen_value < goal) begin
          screen_value_next = screen_value + 7'd1;
        end else if (screen_value > goal) begin
          screen_value_next = screen_value - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_count     <= '0;
      measured_width <= '0;
      accepted_width <= '0;
      limit_persist  <= '0;
      limit_value    <= LIMIT_RESET;
      slew_phase     <= '0;
      screen_value   <= '0;
    end else if (advance) begin
      high_count     <= high_count_next;
      measured_width <= measured_width_next;
      accepted_width <= accepted_width_next;
      limit_persist  <= limit_persist_next;
      limit_value    <= limit_value_next;
      slew_phase     <= slew_phase_next;
      screen_value   <= screen_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_screen  <= screen_value_next;
      out_tracker <= tracker_next;
      out_target  <= target_next;
      out_limit   <= limit_value_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.screen_duty       = out_screen;
  assign result.tracker_duty      = out_tracker;
  assign result.brightness_target = out_target;
  assign result.duty_limit        = out_limit;

  a_screen_slew: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (screen_value == $past(screen_value)) ||
                    (screen_value == $past(screen_value) + 7'd1) ||
                    (screen_value == $past(screen_value) - 7'd1))
    else $error("screen duty moved by more than one step");

  a_count_ceiling: assert property (@(posedge clk) disable iff (rst)
    {1'b0, high_count} <= COUNT_CEIL)
    else $error("high-time counter above its ceiling");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !poll.ready |-> s1_valid && out_valid && !result.ready)
    else $error("poll stalled while the pipeline has room");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bdr_pkg::*;

  localparam int PERIOD       = 100;
  localparam int DEPTH        = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 215;
  localparam int STALL_AT     = 70;
  localparam int PAUSE_AT     = 150;
  localparam int LONG_STALL   = 80;
  localparam int DRAIN_TAIL   = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    duty_t screen;
    duty_t tracker;
    duty_t target;
    duty_t limit;
  } duty_beat_t;

  class duty_scoreboard;
    cfg_t        regs;
    duty_t       high_cnt, meas_width, acc_width, limit_val;
    duty_t       track_val, win_avg, acc_avg, target_val, screen_val;
    logic [7:0]  limit_run;
    logic [9:0]  track_run;
    logic [3:0]  slew_ph;
    int          win_slot;
    duty_t       win[DEPTH];
    duty_beat_t  pending_duty[$];
    int          errors, polls, results;
    int          limit_updates, target_updates, saturations;

    function new();
      regs = CFG_RESET;
      high_cnt = '0; meas_width = '0; acc_width = '0; limit_val = LIMIT_RESET;
      track_val = '0; win_avg = '0; acc_avg = '0; target_val = TARGET_RESET;
      screen_val = '0; limit_run = '0; track_run = '0; slew_ph = '0; win_slot = 0;
      foreach (win[i]) win[i] = '0;
      errors = 0; polls = 0; results = 0;
      limit_updates = 0; target_updates = 0; saturations = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_SCREEN_MIN:   regs.screen_min   = d[6:0];
        REG_SCREEN_MAX:   regs.screen_max   = d[6:0];
        REG_TRACKER_MAX:  regs.tracker_max  = d[6:0];
        REG_TRACKER_STEP: regs.tracker_step = d[3:0];
        REG_CHANGE_BAND:  regs.change_band  = d[3:0];
        REG_TRACKER_HOLD: regs.tracker_hold = d[9:0];
        REG_LIMIT_HOLD:   regs.limit_hold   = d[7:0];
        REG_SLEW_DIVIDER: regs.slew_divider = d[3:0];
        default: ;
      endcase
    endfunction

    function bit off_band(duty_t v, duty_t c, logic [3:0] b);
      return (int'(v) < int'(c) - int'(b)) || (int'(v) > int'(c) + int'(b));
    endfunction

    function void advance_limit();
      if (off_band(meas_width, acc_width, regs.change_band)) begin
        limit_run = limit_run + 8'd1;
        if (limit_run >= regs.limit_hold) begin
          limit_run = '0;
          limit_val = meas_width;
          acc_width = meas_width;
          limit_updates++;
        end
      end else begin
        limit_run = '0;
      end
    endfunction

    function void advance_tracker(bit cmp);
      int t;
      int sum;
      if (cmp) begin
        if (track_val < regs.tracker_max) begin
          t = int'(track_val) + int'(regs.tracker_step);
          if (t > int'(regs.tracker_max)) t = int'(regs.tracker_max);
          track_val = duty_t'(t);
        end
      end else if (track_val != 0) begin
        track_val = (track_val > regs.tracker_step) ? track_val - duty_t'(regs.tracker_step)
                                                    : duty_t'(0);
      end
      win[win_slot] = track_val;
      win_slot++;
      if (win_slot >= DEPTH) begin
        win_slot = 0;
        sum = 0;
        foreach (win[i]) sum += int'(win[i]);
        win_avg = duty_t'(sum / DEPTH);
      end
      if (off_band(win_avg, acc_avg, regs.change_band)) begin
        track_run = track_run + 10'd1;
        if (track_run >= regs.tracker_hold) begin
          track_run = '0;
          target_val = (win_avg < BRIGHT_FULL) ? BRIGHT_FULL - win_avg : duty_t'(0);
          acc_avg = win_avg;
          target_updates++;
        end
      end else begin
        track_run = '0;
      end
    endfunction

    function void advance_slew();
      duty_t goal;
      slew_ph = slew_ph + 4'd1;
      if (slew_ph >= regs.slew_divider) begin
        slew_ph = '0;
        goal = (target_val > limit_val && limit_val != 0) ? limit_val : target_val;
        if (goal > regs.screen_max) goal = regs.screen_max;
        else if (goal < regs.screen_min) goal = regs.screen_min;
        if (screen_val < goal) screen_val = screen_val + 7'd1;
        else if (screen_val > goal) screen_val = screen_val - 7'd1;
      end
    endfunction

    function void note_poll(bit lvl, bit cmp, bit t_us, bit t_ms);
      duty_beat_t want;
      if (lvl) begin
        if (t_us) begin
          high_cnt = high_cnt + 7'd1;
          if (int'(high_cnt) > PERIOD + 5) begin
            meas_width = duty_t'(PERIOD);
            high_cnt = duty_t'(PERIOD);
            saturations++;
          end
        end
      end else begin
        if (high_cnt != 0) meas_width = high_cnt;
        high_cnt = '0;
      end
      if (t_ms) begin
        advance_limit();
        advance_tracker(cmp);
        advance_slew();
      end
      want.screen  = screen_val;
      want.tracker = track_val;
      want.target  = target_val;
      want.limit   = limit_val;
      pending_duty.push_back(want);
      polls++;
    endfunction

    task check_duty(duty_beat_t got);
      duty_beat_t want;
      results++;
      if (pending_duty.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
      end else begin
        want = pending_duty.pop_front();
        if (got.screen != want.screen)
          report($sformatf("result %0d screen_duty %0d, expected %0d",
                           results, got.screen, want.screen));
        if (got.tracker != want.tracker)
          report($sformatf("result %0d tracker_duty %0d, expected %0d",
                           results, got.tracker, want.tracker));
        if (got.target != want.target)
          report($sformatf("result %0d brightness_target %0d, expected %0d",
                           results, got.target, want.target));
        if (got.limit != want.limit)
          report($sformatf("result %0d duty_limit %0d, expected %0d",
                           results, got.limit, want.limit));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  bdr_poll_if poll_ch();
  bdr_duty_if duty_ch();
  bdr_cfg_if  cfg_ch();

  backlight_duty_regulator #(
    .PWM_PERIOD_TICKS(PERIOD),
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .poll(poll_ch),
    .result(duty_ch),
    .cfg(cfg_ch)
  );

  duty_scoreboard sb;
  int send_pct;
  int recv_pct;
  int phase_item;
  int settings;
  int stall_req;
  int stall_seen;
  int stall_left;
  int cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      duty_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_seen <= 0;
    end else if (stall_left != 0) begin
      duty_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      duty_ch.ready <= 1'b0;
    end else begin
      duty_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    duty_beat_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (poll_ch.valid && poll_ch.ready)
        sb.note_poll(poll_ch.pwm_in_level, poll_ch.comparator_high,
                     poll_ch.tick_10us, poll_ch.tick_10ms);
      if (duty_ch.valid && duty_ch.ready) begin
        got.screen  = duty_ch.screen_duty;
        got.tracker = duty_ch.tracker_duty;
        got.target  = duty_ch.brightness_target;
        got.limit   = duty_ch.duty_limit;
        sb.check_duty(got);
      end
    end
  end

  task automatic drain_results();
    poll_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_duty.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic sender_gap();
    int k;
    k = 0;
    while (k < 20 && $urandom_range(99) < send_pct) k++;
    if (k > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  task automatic send_beat(bit lvl, bit cmp, bit t_us, bit t_ms);
    poll_ch.valid           <= 1'b1;
    poll_ch.pwm_in_level    <= lvl;
    poll_ch.comparator_high <= cmp;
    poll_ch.tick_10us       <= t_us;
    poll_ch.tick_10ms       <= t_ms;
    do @(posedge clk); while (!poll_ch.ready);
    phase_item++;
    if (phase_item == STALL_AT) stall_req <= stall_req + 1;
    if (phase_item == PAUSE_AT) drain_results();
    else sender_gap();
  endtask

  task automatic write_cfg(cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    for (int i = 0; i < 8; i++) begin
      case (reg_idx_t'(i))
        REG_SCREEN_MIN:   d = CFG_DATA_W'(c.screen_min);
        REG_SCREEN_MAX:   d = CFG_DATA_W'(c.screen_max);
        REG_TRACKER_MAX:  d = CFG_DATA_W'(c.tracker_max);
        REG_TRACKER_STEP: d = CFG_DATA_W'(c.tracker_step);
        REG_CHANGE_BAND:  d = CFG_DATA_W'(c.change_band);
        REG_TRACKER_HOLD: d = CFG_DATA_W'(c.tracker_hold);
        REG_LIMIT_HOLD:   d = CFG_DATA_W'(c.limit_hold);
        default:          d = CFG_DATA_W'(c.slew_divider);
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_t'(i);
      cfg_ch.data  <= d;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  function automatic cfg_t pick_setting(int ph);
    cfg_t c;
    case (ph)
      1: c = '{screen_min: 7'd1, screen_max: 7'd80, tracker_max: 7'd80, tracker_step: 4'd8,
               change_band: 4'd0, tracker_hold: 10'd1, limit_hold: 8'd1, slew_divider: 4'd1};
      2: c = '{screen_min: 7'd0, screen_max: 7'd0, tracker_max: 7'd0, tracker_step: 4'd1,
               change_band: 4'd0, tracker_hold: 10'd0, limit_hold: 8'd0, slew_divider: 4'd0};
      3: c = '{screen_min: 7'd127, screen_max: 7'd127, tracker_max: 7'd80,
               tracker_step: 4'd8, change_band: 4'd15, tracker_hold: 10'd1023,
               limit_hold: 8'd255, slew_divider: 4'd15};
      4: c = '{screen_min: 7'd100, screen_max: 7'd20, tracker_max: 7'd80, tracker_step: 4'd5,
               change_band: 4'd3, tracker_hold: 10'd2, limit_hold: 8'd3, slew_divider: 4'd2};
      5: c = '{screen_min: 7'd5, screen_max: 7'd60, tracker_max: 7'd10, tracker_step: 4'd3,
               change_band: 4'd1, tracker_hold: 10'd3, limit_hold: 8'd2, slew_divider: 4'd1};
      default: begin
        c.screen_min   = 7'($urandom_range(40, 0));
        c.screen_max   = 7'($urandom_range(127, 20));
        c.tracker_max  = 7'($urandom_range(80, 0));
        c.tracker_step = 4'($urandom_range(8, 1));
        c.change_band  = 4'($urandom_range(15, 0));
        c.tracker_hold = 10'($urandom_range(8, 0));
        c.limit_hold   = 8'($urandom_range(8, 0));
        c.slew_divider = 4'($urandom_range(15, 0));
      end
    endcase
    return c;
  endfunction

  task automatic directed_polls();
    for (int i = 0; i < 16; i++) begin
      send_beat(i[3], i[2], i[1], i[0]);
    end
    repeat (4) send_beat(1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // mostly whole PWM pulses with a comparator that changes in runs; some noise
  task automatic random_polls(int n);
    int sent, w, g, r;
    bit cmp, lvl, t_us, broken;
    cmp = 1'($urandom_range(1));
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        send_beat(1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        r = $urandom_range(99);
        if (r < 80) w = $urandom_range(35, 0);
        else if (r < 95) w = $urandom_range(100, 36);
        else w = $urandom_range(115, 101);
        g = $urandom_range(8, 1);
        broken = ($urandom_range(99) < 10);
        for (int i = 0; i < w + g && sent < n; i++) begin
          if ($urandom_range(99) < 8) cmp = !cmp;
          lvl = (i < w);
          t_us = (lvl && !broken) ? 1'b1 : 1'($urandom_range(1));
          send_beat(lvl, cmp, t_us, $urandom_range(99) < 35);
          sent++;
        end
      end
    end
  endtask

  initial begin
    cfg_t setting;
    sb = new();
    rst = 1'b1;
    settings = 1;
    stall_req <= 0;
    phase_item = 0;
    send_pct = 0;
    recv_pct <= 0;
    poll_ch.valid <= 1'b0;
    poll_ch.pwm_in_level <= 1'b0;
    poll_ch.comparator_high <= 1'b0;
    poll_ch.tick_10us <= 1'b0;
    poll_ch.tick_10ms <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SCREEN_MIN;
    cfg_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_pct = 33;
        recv_pct <= 62;
      end else if (ph < 6) begin
        send_pct = 62;
        recv_pct <= 33;
      end else begin
        send_pct = 0;
        recv_pct <= 0;
      end
      if (ph > 0) begin
        setting = pick_setting(ph);
        write_cfg(setting);
      end
      phase_item = 0;
      if (ph == 0) directed_polls();
      random_polls(PHASE_ITEMS);
      drain_results();
    end

    if (sb.pending_duty.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_duty.size()));
    $display("covered %0d polls and %0d results over %0d register settings",
             sb.polls, sb.results, settings);
    $display("limit accepted %0d times, target updated %0d times, width saturated %0d times",
             sb.limit_updates, sb.target_updates, sb.saturations);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdr_pkg.sv
rtl/bdr_poll_if.sv
rtl/bdr_duty_if.sv
rtl/bdr_cfg_if.sv
rtl/bdr_tracker.sv
rtl/backlight_duty_regulator.sv
tb/sv/tb.sv
